/* rtl/core/tpis_pkg.sv */
// Package for the thermal plant core with low-pass smoothing.
// Holds command types, state codes, register indexes, filter coefficients and
// saturation helpers; no dependencies.
`default_nettype none

package tpis_pkg;

  localparam int unsigned TAP_W     = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd4;

  localparam logic [CFG_W-1:0] AMBIENT_RST  = 32'd1638400;
  localparam logic [CFG_W-1:0] GAIN_LIN_RST = 32'd1174405;
  localparam logic [CFG_W-1:0] GAIN_EFF_RST = 32'd9227469;
  localparam logic [CFG_W-1:0] GAIN_SQ_RST  = 32'd0;
  localparam logic [CFG_W-1:0] STEP_RST     = 32'd92275;

  // Q4.60 coefficients, rounded to nearest from their decimal forms
  localparam logic [127:0] DEC18 = 128'd1000000000000000000;
  localparam logic [127:0] DEC20 = 128'd100000000000000000000;
  localparam logic [127:0] CA0_W = ((128'd67117469390 << 60) + (DEC20 >> 1)) / DEC20;
  localparam logic [127:0] CA1_W = ((128'd268469877561 << 60) + (DEC20 >> 1)) / DEC20;
  localparam logic [127:0] CA2_W = ((128'd402704816342 << 60) + (DEC20 >> 1)) / DEC20;
  localparam logic [127:0] CF1_W =
    ((128'd3972635469928829500 << 60) + (DEC18 >> 1)) / DEC18;
  localparam logic [127:0] CF2_W =
    ((128'd5918280197057419500 << 60) + (DEC18 >> 1)) / DEC18;
  localparam logic [127:0] CF3_W =
    ((128'd3918651000437678000 << 60) + (DEC18 >> 1)) / DEC18;
  localparam logic [127:0] CF4_W =
    ((128'd973006285171913120 << 60) + (DEC18 >> 1)) / DEC18;

  localparam logic [63:0] COEF_A0 = CA0_W[63:0];
  localparam logic [63:0] COEF_A1 = CA1_W[63:0];
  localparam logic [63:0] COEF_A2 = CA2_W[63:0];
  localparam logic [63:0] COEF_F1 = CF1_W[63:0];
  localparam logic [63:0] COEF_F2 = ~CF2_W[63:0] + 64'd1;
  localparam logic [63:0] COEF_F3 = CF3_W[63:0];
  localparam logic [63:0] COEF_F4 = ~CF4_W[63:0] + 64'd1;

  typedef enum logic [2:0] {
    OPS_LIN, OPS_EFF, OPS_SQ, OPS_GSQ, OPS_STEP, OPS_FILT
  } op_sel_t;

  typedef enum logic [2:0] {
    PST_NONE, PST_SUM_LOAD, PST_SUM_ADD8, PST_SQ_SAVE, PST_SUM_ADD16,
    PST_PLANT, PST_FILT
  } post_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_LOAD, ST_MUL, ST_DRAIN, ST_POST, ST_SHIFT,
    ST_FLOAD, ST_FMUL, ST_FDRAIN, ST_FPOST, ST_DONE
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             init;
    logic             load_ops;
    op_sel_t          op_sel;
    logic [TAP_W-1:0] tap;
    logic             fb;
    logic             mul_en;
    logic [1:0]       limb;
    logic             first;
    post_t            post;
    logic             shift;
    logic             out_load;
  } tpis_cmd_t;

  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[127:63];
    hi_zeros = ~|v[127:63];
    if (hi_ones || hi_zeros) begin
      return v[63:0];
    end else if (v[127]) begin
      return {1'b1, 63'd0};
    end else begin
      return {1'b0, {63{1'b1}}};
    end
  endfunction

  function automatic logic signed [63:0] filt_coef(input logic [TAP_W-1:0] tap,
                                                   input logic fb);
    logic signed [63:0] c;
    c = '0;
    if (fb) begin
      unique case (tap)
        4'd1:    c = COEF_F1;
        4'd2:    c = COEF_F2;
        4'd3:    c = COEF_F3;
        4'd4:    c = COEF_F4;
        default: c = '0;
      endcase
    end else begin
      unique case (tap)
        4'd0:    c = COEF_A0;
        4'd1:    c = COEF_A1;
        4'd2:    c = COEF_A2;
        4'd3:    c = COEF_A1;
        4'd4:    c = COEF_A0;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tpis_in_if.sv */
// Request channel: valid/ready handshake with func and value payload.
// No dependencies.
`default_nettype none

interface tpis_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

/* rtl/core/tpis_out_if.sv */
// Result channel: valid/ready handshake with the filtered state payload.
// No dependencies.
`default_nettype none

interface tpis_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_state;

  modport source (output valid, output filtered_state, input ready);
  modport sink   (input valid, input filtered_state, output ready);
endinterface

`default_nettype wire

/* rtl/core/tpis_ctrl.sv */
// Sequencer for the thermal plant core: walks plant products, filter taps and
// result hand-off. Depends on tpis_pkg.
`default_nettype none

module tpis_ctrl #(
  parameter int unsigned FILTER_ORDER = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output tpis_pkg::tpis_cmd_t cmd
);
  import tpis_pkg::*;

  localparam int unsigned KTAPS = (FILTER_ORDER < 4) ? FILTER_ORDER : 4;
  localparam logic [TAP_W-1:0] K_LAST = TAP_W'(2 * KTAPS);
  localparam logic [1:0] LIMB_LAST = 2'd3;

  state_t           state_r, state_nxt;
  op_sel_t          ph_r, ph_nxt;
  logic [1:0]       limb_r, limb_nxt;
  logic [TAP_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= OPS_LIN;
      limb_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      limb_r      <= limb_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    limb_nxt  = limb_r;
    k_nxt     = k_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          ph_nxt      = OPS_LIN;
          state_nxt   = in_func ? ST_INIT : ST_LOAD;
        end
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_LOAD: begin
        cmd.load_ops = 1'b1;
        cmd.op_sel   = ph_r;
        limb_nxt     = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.limb   = limb_r;
        cmd.first  = (limb_r == '0);
        limb_nxt   = limb_r + 2'd1;
        if (limb_r == LIMB_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_POST;
      end
      ST_POST: begin
        state_nxt = ST_LOAD;
        unique case (ph_r)
          OPS_LIN: begin
            cmd.post = PST_SUM_LOAD;
            ph_nxt   = OPS_EFF;
          end
          OPS_EFF: begin
            cmd.post = PST_SUM_ADD8;
            ph_nxt   = OPS_SQ;
          end
          OPS_SQ: begin
            cmd.post = PST_SQ_SAVE;
            ph_nxt   = OPS_GSQ;
          end
          OPS_GSQ: begin
            cmd.post = PST_SUM_ADD16;
            ph_nxt   = OPS_STEP;
          end
          OPS_STEP: begin
            cmd.post  = PST_PLANT;
            state_nxt = ST_SHIFT;
          end
          default: begin
            cmd.post  = PST_NONE;
            state_nxt = ST_SHIFT;
          end
        endcase
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        k_nxt     = '0;
        state_nxt = ST_FLOAD;
      end
      ST_FLOAD: begin
        cmd.load_ops = 1'b1;
        cmd.op_sel   = OPS_FILT;
        cmd.tap      = (k_r + TAP_W'(1)) >> 1;
        cmd.fb       = (k_r != '0) && !k_r[0];
        limb_nxt     = '0;
        state_nxt    = ST_FMUL;
      end
      ST_FMUL: begin
        cmd.mul_en = 1'b1;
        cmd.limb   = limb_r;
        cmd.first  = (k_r == '0) && (limb_r == '0);
        limb_nxt   = limb_r + 2'd1;
        if (limb_r == LIMB_LAST) begin
          if (k_r == K_LAST) begin
            state_nxt = ST_FDRAIN;
          end else begin
            k_nxt     = k_r + TAP_W'(1);
            state_nxt = ST_FLOAD;
          end
        end
      end
      ST_FDRAIN: begin
        state_nxt = ST_FPOST;
      end
      ST_FPOST: begin
        cmd.post  = PST_FILT;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/tpis_datapath.sv */
// Datapath for the thermal plant core: configuration registers, plant level,
// filter taps, shared 33x33 multiplier with 128-bit accumulator, result register.
// Depends on tpis_pkg.
`default_nettype none

module tpis_datapath #(
  parameter int unsigned FILTER_ORDER = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tpis_pkg::tpis_cmd_t               cmd,
  input  logic signed [31:0]                in_value,
  input  logic                              cfg_we,
  input  logic [tpis_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tpis_pkg::CFG_W-1:0]        cfg_wdata,
  output logic signed [31:0]                out_data
);
  import tpis_pkg::*;

  localparam int unsigned NTAPS = FILTER_ORDER + 1;

  logic signed [31:0]  amb_r, amb_nxt;
  logic [31:0]         gl_r, gl_nxt;
  logic [31:0]         ge_r, ge_nxt;
  logic [31:0]         gs_r, gs_nxt;
  logic [31:0]         st_r, st_nxt;

  logic signed [63:0]  plant_r, plant_nxt;
  logic signed [63:0]  in_hist_r  [NTAPS];
  logic signed [63:0]  in_hist_nxt [NTAPS];
  logic signed [63:0]  out_hist_r [NTAPS];
  logic signed [63:0]  out_hist_nxt [NTAPS];

  logic signed [31:0]  val_r, val_nxt;
  logic signed [63:0]  op_a_r, op_a_nxt;
  logic signed [63:0]  op_b_r, op_b_nxt;
  logic signed [65:0]  pp_r, pp_nxt;
  logic [1:0]          pp_sh_r, pp_sh_nxt;
  logic                pp_first_r, pp_first_nxt;
  logic                pp_v_r, pp_v_nxt;
  logic signed [127:0] acc_r, acc_nxt;
  logic signed [127:0] sum_r, sum_nxt;
  logic [56:0]         q_r, q_nxt;
  logic signed [63:0]  y_r, y_nxt;
  logic signed [31:0]  out_data_r, out_data_nxt;

  logic signed [48:0]  d32;
  logic signed [28:0]  d12;
  logic signed [63:0]  in_sel;
  logic signed [63:0]  out_sel;
  logic signed [32:0]  a_limb;
  logic signed [32:0]  b_limb;
  logic signed [65:0]  pp;
  logic signed [127:0] ppx;
  logic signed [127:0] acc_sh8;
  logic signed [127:0] acc_sh16;
  logic signed [127:0] acc_sh24;
  logic signed [127:0] acc_sh60;
  logic signed [127:0] plant_ext;
  logic signed [127:0] plant_sum;
  logic signed [63:0]  y_filt;
  logic signed [63:0]  init_level;

  // configuration
  always_comb begin
    amb_nxt = amb_r;
    gl_nxt  = gl_r;
    ge_nxt  = ge_r;
    gs_nxt  = gs_r;
    st_nxt  = st_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AMBIENT:  amb_nxt = cfg_wdata;
        CFG_GAIN_LIN: gl_nxt  = cfg_wdata;
        CFG_GAIN_EFF: ge_nxt  = cfg_wdata;
        CFG_GAIN_SQ:  gs_nxt  = cfg_wdata;
        CFG_STEP:     st_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand selection
  always_comb begin
    d32 = {amb_r[31], amb_r, 16'd0} - {plant_r[63], plant_r[63:16]};
    d12 = d32[48:20];
    in_sel  = '0;
    out_sel = '0;
    for (int i = 0; i < NTAPS; i++) begin
      if (cmd.tap == TAP_W'(i)) begin
        in_sel  = in_hist_r[i];
        out_sel = out_hist_r[i];
      end
    end
    unique case (cmd.op_sel)
      OPS_LIN: begin
        op_a_nxt = {32'd0, gl_r};
        op_b_nxt = {{15{d32[48]}}, d32};
      end
      OPS_EFF: begin
        op_a_nxt = {32'd0, ge_r};
        op_b_nxt = {{32{val_r[31]}}, val_r};
      end
      OPS_SQ: begin
        op_a_nxt = {{35{d12[28]}}, d12};
        op_b_nxt = {{35{d12[28]}}, d12};
      end
      OPS_GSQ: begin
        op_a_nxt = {32'd0, gs_r};
        op_b_nxt = {7'd0, q_r};
      end
      OPS_STEP: begin
        op_a_nxt = {32'd0, st_r};
        op_b_nxt = sat64(sum_r);
      end
      OPS_FILT: begin
        op_a_nxt = filt_coef(cmd.tap, cmd.fb);
        op_b_nxt = cmd.fb ? out_sel : in_sel;
      end
      default: begin
        op_a_nxt = '0;
        op_b_nxt = '0;
      end
    endcase
    if (!cmd.load_ops) begin
      op_a_nxt = op_a_r;
      op_b_nxt = op_b_r;
    end
  end

  // partial products and accumulation
  always_comb begin
    a_limb = cmd.limb[1] ? {op_a_r[63], op_a_r[63:32]} : {1'b0, op_a_r[31:0]};
    b_limb = cmd.limb[0] ? {op_b_r[63], op_b_r[63:32]} : {1'b0, op_b_r[31:0]};
    pp     = a_limb * b_limb;
    pp_nxt       = pp;
    pp_sh_nxt    = {1'b0, cmd.limb[1]} + {1'b0, cmd.limb[0]};
    pp_first_nxt = cmd.first;
    pp_v_nxt     = cmd.mul_en;
    ppx = {{62{pp_r[65]}}, pp_r} << {pp_sh_r, 5'd0};
    acc_nxt = acc_r;
    if (pp_v_r) begin
      acc_nxt = (pp_first_r ? 128'sd0 : acc_r) + ppx;
    end
  end

  // result handling
  always_comb begin
    acc_sh8    = acc_r >>> 8;
    acc_sh16   = acc_r >>> 16;
    acc_sh24   = acc_r >>> 24;
    acc_sh60   = acc_r >>> 60;
    plant_ext  = {{64{plant_r[63]}}, plant_r};
    plant_sum  = plant_ext + acc_sh8;
    y_filt     = sat64(acc_sh60);
    init_level = {val_r, 32'd0};

    val_nxt      = cmd.capture ? in_value : val_r;
    sum_nxt      = sum_r;
    q_nxt        = q_r;
    plant_nxt    = plant_r;
    y_nxt        = y_r;
    out_data_nxt = cmd.out_load ? y_r[63:32] : out_data_r;
    for (int i = 0; i < NTAPS; i++) begin
      in_hist_nxt[i]  = in_hist_r[i];
      out_hist_nxt[i] = out_hist_r[i];
    end

    if (cmd.init) begin
      plant_nxt = init_level;
      y_nxt     = init_level;
      for (int i = 0; i < NTAPS; i++) begin
        in_hist_nxt[i]  = init_level;
        out_hist_nxt[i] = init_level;
      end
    end else if (cmd.shift) begin
      in_hist_nxt[0] = plant_r;
      for (int i = 1; i < NTAPS; i++) begin
        in_hist_nxt[i]  = in_hist_r[i-1];
        out_hist_nxt[i] = out_hist_r[i-1];
      end
    end

    unique case (cmd.post)
      PST_NONE: ;
      PST_SUM_LOAD:  sum_nxt = acc_sh24;
      PST_SUM_ADD8:  sum_nxt = sum_r + acc_sh8;
      PST_SQ_SAVE:   q_nxt   = acc_r[56:0];
      PST_SUM_ADD16: sum_nxt = sum_r + acc_sh16;
      PST_PLANT:     plant_nxt = sat64(plant_sum);
      PST_FILT: begin
        y_nxt           = y_filt;
        out_hist_nxt[0] = y_filt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amb_r   <= AMBIENT_RST;
      gl_r    <= GAIN_LIN_RST;
      ge_r    <= GAIN_EFF_RST;
      gs_r    <= GAIN_SQ_RST;
      st_r    <= STEP_RST;
      plant_r <= '0;
      pp_v_r  <= 1'b0;
      for (int i = 0; i < NTAPS; i++) begin
        in_hist_r[i]  <= '0;
        out_hist_r[i] <= '0;
      end
    end else begin
      amb_r   <= amb_nxt;
      gl_r    <= gl_nxt;
      ge_r    <= ge_nxt;
      gs_r    <= gs_nxt;
      st_r    <= st_nxt;
      plant_r <= plant_nxt;
      pp_v_r  <= pp_v_nxt;
      for (int i = 0; i < NTAPS; i++) begin
        in_hist_r[i]  <= in_hist_nxt[i];
        out_hist_r[i] <= out_hist_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    pp_r       <= pp_nxt;
    pp_sh_r    <= pp_sh_nxt;
    pp_first_r <= pp_first_nxt;
    acc_r      <= acc_nxt;
    sum_r      <= sum_nxt;
    q_r        <= q_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/thermal_plant_with_iir_smoothing_core.sv */
// Top level of the thermal plant core with fourth-order low-pass smoothing.
// Depends on tpis_pkg, tpis_in_if, tpis_out_if, tpis_ctrl, tpis_datapath.
//
// port       dir  payload                  handshake
// in_chan    in   func, value              valid / ready
// out_chan   out  filtered_state           valid / ready
// cfg_*      in   cfg_idx, cfg_wdata       cfg_we, always taken
//
// A step request runs the plant products, a history shift and 2*min(FILTER_ORDER,4)+1
// filter taps before its result is loaded; an initialise request passes through init to done.
// The pace is set by the single 33x33 multiplier: each 64x64 product is four
// partial products plus an operand load, one product at a time.
// Reset is synchronous; it restores register defaults and clears plant and taps.
// One result register: the next request is accepted while a result waits, and a
// finished request holds in the done state until that register frees.
`default_nettype none

module thermal_plant_with_iir_smoothing_core #(
  parameter int unsigned FILTER_ORDER = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tpis_in_if.sink                        in_chan,
  tpis_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [tpis_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tpis_pkg::CFG_W-1:0]     cfg_wdata
);
  import tpis_pkg::*;

  tpis_cmd_t cmd;

  tpis_ctrl #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_func   (in_chan.func),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  tpis_datapath #(
    .FILTER_ORDER (FILTER_ORDER)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_chan.value),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_chan.filtered_state)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_chan.valid || out_chan.ready))
    else $error("result loaded over an untaken result");

  a_post_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.post != PST_NONE) |-> !$past(cmd.mul_en))
    else $error("accumulator read before the last partial product landed");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !$rose(out_chan.valid))
    else $error("result raised right after a request was accepted");

endmodule

`default_nettype wire

/* dv/tpis_filtered_state_checker.sv */
// Checker for the thermal plant core: watches the request, result and register ports,
// predicts each filtered state and compares it with the result channel.
// Depends on tpis_pkg for port widths and register indexes.

module tpis_filtered_state_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_func,
  input  logic signed [31:0]             in_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [31:0]             out_filtered_state,
  input  logic                           cfg_we,
  input  logic [tpis_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tpis_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending
);
  import tpis_pkg::*;

  localparam int NTAP = 5;

  typedef logic signed [63:0]  q64_t;
  typedef logic signed [127:0] q128_t;

  localparam q128_t TOP64 = (128'sd1 <<< 63) - 128'sd1;
  localparam q128_t BOT64 = -(128'sd1 <<< 63);

  logic signed [31:0] ambient;
  logic [31:0]        k_lin;
  logic [31:0]        k_eff;
  logic [31:0]        k_sq;
  logic [31:0]        k_step;
  q64_t               level;
  q64_t               x_hist [NTAP];
  q64_t               y_hist [NTAP];
  q64_t               ff_coef [NTAP];
  q64_t               fb_coef [NTAP];
  logic signed [31:0] filtered_q [$];

  function automatic q64_t q60_round(input logic [127:0] num, input int digits);
    logic [127:0] den;
    logic [127:0] q;
    den = 128'd1;
    repeat (digits) den = den * 128'd10;
    q = ((num << 60) + (den >> 1)) / den;
    return q[63:0];
  endfunction

  function automatic q128_t widen(input q64_t v);
    return {{64{v[63]}}, v};
  endfunction

  function automatic q64_t clamp64(input q128_t v);
    if (v > TOP64) begin
      return TOP64[63:0];
    end else if (v < BOT64) begin
      return BOT64[63:0];
    end
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] advance_plant(input logic load_level,
                                                       input logic signed [31:0] val);
    q64_t  amb64;
    q64_t  val64;
    q64_t  d32;
    q64_t  d12;
    q64_t  sqr;
    q64_t  drive;
    q64_t  y0;
    q64_t  g_lin;
    q64_t  g_eff;
    q64_t  g_sq;
    q64_t  g_step;
    q128_t acc;
    amb64  = {{32{ambient[31]}}, ambient};
    val64  = {{32{val[31]}}, val};
    g_lin  = {32'd0, k_lin};
    g_eff  = {32'd0, k_eff};
    g_sq   = {32'd0, k_sq};
    g_step = {32'd0, k_step};
    if (load_level) begin
      level = {val, 32'd0};
      for (int i = 0; i < NTAP; i++) begin
        x_hist[i] = level;
        y_hist[i] = level;
      end
      y0 = level;
    end else begin
      d32 = (amb64 <<< 16) - (level >>> 16);
      d12 = d32 >>> 20;
      sqr = d12 * d12;
      acc = (widen(g_lin) * widen(d32)) >>> 24;
      acc = acc + ((widen(g_eff) * widen(val64)) >>> 8);
      acc = acc + ((widen(g_sq) * widen(sqr)) >>> 16);
      drive = clamp64(acc);
      level = clamp64(widen(level) + ((widen(g_step) * widen(drive)) >>> 8));
      for (int i = NTAP - 1; i > 0; i--) begin
        x_hist[i] = x_hist[i-1];
        y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = level;
      acc = widen(ff_coef[0]) * widen(x_hist[0]);
      for (int i = 1; i < NTAP; i++) begin
        acc = acc + widen(ff_coef[i]) * widen(x_hist[i])
                  + widen(fb_coef[i]) * widen(y_hist[i]);
      end
      y0 = clamp64(acc >>> 60);
      y_hist[0] = y0;
    end
    return y0[63:32];
  endfunction

  initial begin
    ff_coef[0] = q60_round(128'd67117469390, 20);
    ff_coef[1] = q60_round(128'd268469877561, 20);
    ff_coef[2] = q60_round(128'd402704816342, 20);
    ff_coef[3] = ff_coef[1];
    ff_coef[4] = ff_coef[0];
    fb_coef[0] = '0;
    fb_coef[1] = q60_round(128'd3972635469928829500, 18);
    fb_coef[2] = -q60_round(128'd5918280197057419500, 18);
    fb_coef[3] = q60_round(128'd3918651000437678000, 18);
    fb_coef[4] = -q60_round(128'd973006285171913120, 18);
  end

  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst_n) begin
      ambient = 32'sd1638400;
      k_lin   = 32'd1174405;
      k_eff   = 32'd9227469;
      k_sq    = 32'd0;
      k_step  = 32'd92275;
      level   = '0;
      for (int i = 0; i < NTAP; i++) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_AMBIENT:  ambient = cfg_wdata;
          CFG_GAIN_LIN: k_lin = cfg_wdata;
          CFG_GAIN_EFF: k_eff = cfg_wdata;
          CFG_GAIN_SQ:  k_sq = cfg_wdata;
          CFG_STEP:     k_step = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        filtered_q.push_back(advance_plant(in_func, in_value));
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected filtered_state, expected none, actual %0d",
                   $time, out_filtered_state);
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_filtered_state) begin
            fail_count++;
            $display("%0t: filtered_state mismatch, expected %0d, actual %0d",
                     $time, want, out_filtered_state);
          end
        end
      end
    end
    pending <= filtered_q.size();
  end

endmodule

/* dv/tb_thermal_plant_with_iir_smoothing_core.sv */
// Testbench top for the thermal plant core: clock, reset, register writes,
// directed and random requests with idling on both channels, watchdog and verdict.
// Depends on tpis_pkg, tpis_in_if, tpis_out_if, the core and tpis_filtered_state_checker.

module tb_thermal_plant_with_iir_smoothing_core;
  import tpis_pkg::*;

  localparam int   ITEM_GOAL   = 850;
  localparam int   QUIET_TAIL  = 120;
  localparam int   QUIET_LIMIT = 4000;
  localparam int   TAIL_CYCLES = 120;
  localparam logic FUNC_STEP   = 1'b0;
  localparam logic FUNC_INIT   = 1'b1;

  typedef enum int {
    SET_DEFAULT, SET_MAX, SET_MIN, SET_PLANT, SET_RANDOM, SET_MIXED
  } setting_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   gap_pct;
  int                   stall_pct;
  int                   sent;

  tpis_in_if  in_chan ();
  tpis_out_if out_chan ();

  thermal_plant_with_iir_smoothing_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  tpis_filtered_state_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_chan.valid),
    .in_ready           (in_chan.ready),
    .in_func            (in_chan.func),
    .in_value           (in_chan.value),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_filtered_state (out_chan.filtered_state),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  initial begin
    int idle_n;
    idle_n = 0;
    while (idle_n < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_n = 0;
      end else begin
        idle_n++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
      2: begin
        v = $urandom_range(0, 32'h03FF_FFFF);
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 32'sd0;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: v = $urandom_range(0, 100 << 16) - (20 << 16);
    endcase
    return v;
  endfunction

  task automatic send_request(input logic f, input logic signed [31:0] v);
    if (sent >= ITEM_GOAL - QUIET_TAIL) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func  <= f;
    in_chan.value <= v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input setting_t mode);
    logic [CFG_W-1:0] v [5];
    case (mode)
      SET_DEFAULT: begin
        v = '{32'd1638400, 32'd1174405, 32'd9227469, 32'd0, 32'd92275};
      end
      SET_MAX: begin
        v = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      end
      SET_MIN: begin
        v = '{32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0};
      end
      SET_PLANT: begin
        v[0] = $urandom_range(0, 100 << 16) - (20 << 16);
        v[1] = $urandom_range(0, 1 << 24);
        v[2] = $urandom_range(0, 1 << 24);
        v[3] = $urandom_range(0, 1 << 16);
        v[4] = $urandom_range(0, 1 << 22);
      end
      SET_RANDOM: begin
        foreach (v[k]) v[k] = $urandom;
      end
      default: begin
        foreach (v[k]) begin
          case ($urandom_range(0, 2))
            0:       v[k] = '0;
            1:       v[k] = '1;
            default: v[k] = $urandom;
          endcase
        end
      end
    endcase
    write_reg(CFG_AMBIENT, v[0]);
    write_reg(CFG_GAIN_LIN, v[1]);
    write_reg(CFG_GAIN_EFF, v[2]);
    write_reg(CFG_GAIN_SQ, v[3]);
    write_reg(CFG_STEP, v[4]);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    int done_n;
    done_n = 0;
    while (done_n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        send_request(FUNC_INIT, pick_value());
        done_n++;
        repeat ($urandom_range(4, 30)) begin
          send_request(FUNC_STEP, pick_value());
          done_n++;
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_request(logic'($urandom_range(0, 1)), $urandom);
          done_n++;
        end
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    in_chan.valid <= 1'b0;
    in_chan.func  <= FUNC_STEP;
    in_chan.value <= '0;
    gap_pct   = 20;
    stall_pct = 5;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_request(FUNC_STEP, 32'sd0);
    send_request(FUNC_STEP, 32'sh7FFF_FFFF);
    send_request(FUNC_STEP, 32'sh8000_0000);
    send_request(FUNC_INIT, 32'sd1638400);
    send_request(FUNC_STEP, 32'sd0);
    send_request(FUNC_STEP, 32'sd65536);
    send_request(FUNC_INIT, 32'sh7FFF_FFFF);
    send_request(FUNC_STEP, 32'sd0);
    send_request(FUNC_INIT, 32'sh8000_0000);
    send_request(FUNC_STEP, -32'sd1);
    send_request(FUNC_INIT, 32'sd0);
    send_request(FUNC_STEP, 32'sd0);
    drain();

    for (int i = int'(CFG_STEP) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 32'hFFFF_FFFF);
    end
    cfg_we <= 1'b0;
    send_request(FUNC_STEP, 32'sd65536);
    send_request(FUNC_STEP, 32'sd65536);
    drain();

    apply_setting(SET_MAX);
    send_request(FUNC_INIT, 32'sh8000_0000);
    send_request(FUNC_STEP, 32'sh7FFF_FFFF);
    send_request(FUNC_STEP, 32'sh7FFF_FFFF);
    send_request(FUNC_STEP, 32'sh8000_0000);
    send_request(FUNC_INIT, 32'sh7FFF_FFFF);
    send_request(FUNC_STEP, 32'sd0);
    drain();

    apply_setting(SET_MIN);
    send_request(FUNC_STEP, 32'sd0);
    send_request(FUNC_INIT, 32'sd12345);
    send_request(FUNC_STEP, 32'sh7FFF_FFFF);
    drain();

    apply_setting(SET_PLANT);
    while (sent < ITEM_GOAL) begin
      if (sent >= ITEM_GOAL - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       begin gap_pct = 0;  stall_pct = 0;  end
          1:       begin gap_pct = 25; stall_pct = 3;  end
          default: begin gap_pct = 60; stall_pct = 10; end
        endcase
      end
      run_phase($urandom_range(60, 120));
      drain();
      apply_setting(setting_t'($urandom_range(0, 5)));
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
